### hw/rtl/slu_pkg.sv
// Shared types and codes of the string literal unescaper.
package slu_pkg;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_UNTERM  = 3'd1;
	localparam logic [2:0] ERR_BADESC  = 3'd2;
	localparam logic [2:0] ERR_NOPLUS  = 3'd3;
	localparam logic [2:0] ERR_EMPTY   = 3'd4;
	localparam logic [2:0] ERR_OVFL    = 3'd5;

	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_PLUS = 8'h2B;

	typedef enum logic [6:0] {
		MODE_IDLE   = 7'b0000001,
		MODE_FIRST  = 7'b0000010,
		MODE_SECOND = 7'b0000100,
		MODE_BODY   = 7'b0001000,
		MODE_ESC    = 7'b0010000,
		MODE_PLUS   = 7'b0100000,
		MODE_HEX    = 7'b1000000
	} slu_mode_t;

	// All results of one input item; later results carry only an 8-bit code.
	typedef struct packed {
		logic [1:0]  cnt;
		logic [1:0]  r0_kind;
		logic [31:0] r0_code;
		logic [2:0]  r0_err;
		logic        r0_nc;
		logic [1:0]  r1_kind;
		logic [2:0]  r1_err;
		logic [7:0]  r1_code;
		logic [7:0]  r2_code;
	} slu_bundle_t;

endpackage

### hw/rtl/string_literal_unescaper_core.sv
// Top level of the string literal unescaper.
// Input queue port: action and source_byte are taken at a clock edge with push high
// and full low. A start item names the opening quote, byte items carry the literal,
// an end item closes the input.
// Result queue port: while empty is low the oldest result stands on kind, char_code,
// error_code, byte_not_consumed and last; pop with empty low takes it. last marks the
// final result of one input item; an item may give zero to three results.
// Throughput: one input item per cycle while results are taken as fast as they come.
// An item with several results gives one per cycle while pop is held high.
// The queue registers each bundle; its results show once the bundle is at the head.
// The scanner runs ahead of the result port through a queue of QUEUE_DEPTH bundles;
// when the receiver stalls the queue fills and full rises, holding the sender.
// Reset clears the scanner to idle and empties the queue; a literal in progress
// is lost.
module string_literal_unescaper_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [7:0]  source_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [31:0] char_code,
	output logic [2:0]  error_code,
	output logic        byte_not_consumed,
	output logic        last
);
	import slu_pkg::*;

	slu_bundle_t fr_bnd;
	slu_bundle_t head;
	logic        fr_push;
	logic        head_pop;
	logic        accept;

	assign accept = push && !full;

	slu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (action),
		.source_byte (source_byte),
		.bnd_push    (fr_push),
		.bnd         (fr_bnd)
	);

	slu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.wdata  (fr_bnd),
		.full   (full),
		.pop    (head_pop),
		.rdata  (head),
		.empty  (empty)
	);

	slu_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head              (head),
		.head_empty        (empty),
		.head_pop          (head_pop),
		.pop               (pop),
		.kind              (kind),
		.char_code         (char_code),
		.error_code        (error_code),
		.byte_not_consumed (byte_not_consumed),
		.last              (last)
	);

`ifndef SYNTHESIS
	a_err_code_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != KIND_ERR) |-> (error_code == ERR_NONE))
		else $error("error code on a result that is not an error");

	a_nc_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && byte_not_consumed) |-> (kind == KIND_DONE && last))
		else $error("unconsumed byte flag outside a final done result");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == KIND_DONE || kind == KIND_ERR)) |-> last)
		else $error("done or error result is not the last of its item");
`endif

endmodule

### hw/rtl/slu_front.sv
// Front end: scans one accepted item per cycle and classifies it into a result bundle.
module slu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         action,
	input  logic [7:0]         source_byte,
	output logic               bnd_push,
	output slu_pkg::slu_bundle_t bnd
);
	import slu_pkg::*;

	slu_mode_t   mode_q, mode_d;
	logic [7:0]  quote_q, quote_d;
	logic        triple_q, triple_d;
	logic [1:0]  pend_q, pend_d;
	logic [31:0] acc_q, acc_d;
	logic        dig_q, dig_d;
	logic        ovf_q, ovf_d;
	logic        idle_d;
	logic        start_d;
	logic [4:0]  hex;
	logic [9:0]  esc;

	function automatic logic [4:0] hex_dec(input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

	// {simple escape, unicode escape, character}
	function automatic logic [9:0] esc_dec(input logic [7:0] b);
		logic [9:0] r;
		r = '0;
		unique case (b)
			8'h27:   r = {2'b10, 8'd39};
			8'h22:   r = {2'b10, 8'd34};
			8'h5C:   r = {2'b10, 8'd92};
			8'h61:   r = {2'b10, 8'd7};
			8'h62:   r = {2'b10, 8'd8};
			8'h66:   r = {2'b10, 8'd12};
			8'h6E:   r = {2'b10, 8'd10};
			8'h72:   r = {2'b10, 8'd13};
			8'h74:   r = {2'b10, 8'd9};
			8'h76:   r = {2'b10, 8'd11};
			8'h55,
			8'h75:   r = {2'b01, 8'd0};
			default: r = '0;
		endcase
		return r;
	endfunction

	assign hex = hex_dec(source_byte);
	assign esc = esc_dec(source_byte);

	always_comb begin
		mode_d   = mode_q;
		quote_d  = quote_q;
		triple_d = triple_q;
		pend_d   = pend_q;
		acc_d    = acc_q;
		dig_d    = dig_q;
		ovf_d    = ovf_q;
		idle_d   = 1'b0;
		start_d  = 1'b0;
		bnd      = '0;
		unique case (action)
			ACT_START: begin
				idle_d  = 1'b1;
				start_d = 1'b1;
				quote_d = source_byte;
			end
			ACT_BYTE: begin
				unique case (mode_q)
					MODE_FIRST, MODE_BODY: begin
						if (mode_q == MODE_FIRST && source_byte == quote_q) begin
							mode_d = MODE_SECOND;
						end else if (mode_q == MODE_BODY && triple_q) begin
							if (source_byte == quote_q) begin
								if (pend_q[1]) begin
									bnd.cnt     = 2'd1;
									bnd.r0_kind = KIND_DONE;
									idle_d      = 1'b1;
								end else begin
									pend_d = pend_q + 2'd1;
								end
							end else begin
								pend_d = '0;
								priority if (pend_q[1]) begin
									bnd.cnt     = 2'd3;
									bnd.r0_code = {24'd0, quote_q};
									bnd.r1_code = quote_q;
									bnd.r2_code = source_byte;
								end else if (pend_q[0]) begin
									bnd.cnt     = 2'd2;
									bnd.r0_code = {24'd0, quote_q};
									bnd.r1_code = source_byte;
								end else begin
									bnd.cnt     = 2'd1;
									bnd.r0_code = {24'd0, source_byte};
								end
							end
						end else if (source_byte == CH_BSL) begin
							mode_d = MODE_ESC;
						end else if (source_byte == quote_q) begin
							bnd.cnt     = 2'd1;
							bnd.r0_kind = KIND_DONE;
							idle_d      = 1'b1;
						end else begin
							mode_d      = MODE_BODY;
							bnd.cnt     = 2'd1;
							bnd.r0_code = {24'd0, source_byte};
						end
					end
					MODE_SECOND, MODE_ESC: begin
						if (mode_q == MODE_SECOND && source_byte == quote_q) begin
							triple_d = 1'b1;
							pend_d   = '0;
							mode_d   = MODE_BODY;
						end else if (mode_q == MODE_SECOND && quote_q != CH_BSL) begin
							bnd.cnt     = 2'd1;
							bnd.r0_kind = KIND_DONE;
							bnd.r0_nc   = 1'b1;
							idle_d      = 1'b1;
						end else if (esc[9]) begin
							mode_d      = MODE_BODY;
							bnd.cnt     = 2'd1;
							bnd.r0_code = {24'd0, esc[7:0]};
						end else if (esc[8]) begin
							mode_d = MODE_PLUS;
						end else begin
							bnd.cnt     = 2'd1;
							bnd.r0_kind = KIND_ERR;
							bnd.r0_err  = ERR_BADESC;
							idle_d      = 1'b1;
						end
					end
					MODE_PLUS: begin
						if (source_byte == CH_PLUS) begin
							mode_d = MODE_HEX;
						end else begin
							bnd.cnt     = 2'd1;
							bnd.r0_kind = KIND_ERR;
							bnd.r0_err  = ERR_NOPLUS;
							idle_d      = 1'b1;
						end
					end
					MODE_HEX: begin
						if (hex[4]) begin
							if (acc_q[31:28] != 4'd0) ovf_d = 1'b1;
							acc_d = {acc_q[27:0], hex[3:0]};
							dig_d = 1'b1;
						end else if (!dig_q || ovf_q) begin
							bnd.cnt     = 2'd1;
							bnd.r0_kind = KIND_ERR;
							bnd.r0_err  = dig_q ? ERR_OVFL : ERR_EMPTY;
							idle_d      = 1'b1;
						end else begin
							acc_d       = '0;
							dig_d       = 1'b0;
							bnd.cnt     = 2'd1;
							bnd.r0_code = acc_q;
							if (source_byte == CH_BSL) begin
								mode_d = MODE_ESC;
							end else if (source_byte == quote_q) begin
								bnd.cnt     = 2'd2;
								bnd.r1_kind = KIND_DONE;
								idle_d      = 1'b1;
							end else begin
								mode_d      = MODE_BODY;
								bnd.cnt     = 2'd2;
								bnd.r1_code = source_byte;
							end
						end
					end
					default: ;
				endcase
			end
			ACT_END: begin
				unique case (mode_q)
					MODE_FIRST, MODE_BODY: begin
						bnd.cnt     = 2'd1;
						bnd.r0_kind = KIND_ERR;
						bnd.r0_err  = ERR_UNTERM;
						idle_d      = 1'b1;
					end
					MODE_SECOND: begin
						bnd.cnt = 2'd1;
						idle_d  = 1'b1;
						if (quote_q == CH_BSL) begin
							bnd.r0_kind = KIND_ERR;
							bnd.r0_err  = ERR_BADESC;
						end else begin
							bnd.r0_kind = KIND_DONE;
						end
					end
					MODE_ESC: begin
						bnd.cnt     = 2'd1;
						bnd.r0_kind = KIND_ERR;
						bnd.r0_err  = ERR_BADESC;
						idle_d      = 1'b1;
					end
					MODE_PLUS: begin
						bnd.cnt     = 2'd1;
						bnd.r0_kind = KIND_ERR;
						bnd.r0_err  = ERR_NOPLUS;
						idle_d      = 1'b1;
					end
					MODE_HEX: begin
						bnd.cnt = 2'd1;
						idle_d  = 1'b1;
						if (!dig_q || ovf_q) begin
							bnd.r0_kind = KIND_ERR;
							bnd.r0_err  = dig_q ? ERR_OVFL : ERR_EMPTY;
						end else begin
							bnd.cnt     = 2'd2;
							bnd.r0_code = acc_q;
							bnd.r1_kind = KIND_ERR;
							bnd.r1_err  = ERR_UNTERM;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (idle_d) begin
			mode_d   = MODE_IDLE;
			triple_d = 1'b0;
			pend_d   = '0;
			acc_d    = '0;
			dig_d    = 1'b0;
			ovf_d    = 1'b0;
		end
		if (start_d) mode_d = MODE_FIRST;
	end

	assign bnd_push = accept && (bnd.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			quote_q  <= '0;
			triple_q <= 1'b0;
			pend_q   <= '0;
			acc_q    <= '0;
			dig_q    <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			quote_q  <= quote_d;
			triple_q <= triple_d;
			pend_q   <= pend_d;
			acc_q    <= acc_d;
			dig_q    <= dig_d;
			ovf_q    <= ovf_d;
		end
	end

endmodule

### hw/rtl/slu_queue.sv
// Bundle queue between the front end and the result serializer.
module slu_queue #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  slu_pkg::slu_bundle_t wdata,
	output logic                 full,
	input  logic                 pop,
	output slu_pkg::slu_bundle_t rdata,
	output logic                 empty
);
	import slu_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	slu_bundle_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop) count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule

### hw/rtl/slu_back.sv
// Back end: hands out the results of the head bundle one transaction at a time.
module slu_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slu_pkg::slu_bundle_t head,
	input  logic                 head_empty,
	output logic                 head_pop,
	input  logic                 pop,
	output logic [1:0]           kind,
	output logic [31:0]          char_code,
	output logic [2:0]           error_code,
	output logic                 byte_not_consumed,
	output logic                 last
);
	import slu_pkg::*;

	logic [1:0] idx_q;
	logic       take;

	always_comb begin
		kind              = KIND_CHAR;
		char_code         = '0;
		error_code        = ERR_NONE;
		byte_not_consumed = 1'b0;
		unique case (idx_q)
			2'd0: begin
				kind              = head.r0_kind;
				char_code         = head.r0_code;
				error_code        = head.r0_err;
				byte_not_consumed = head.r0_nc;
			end
			2'd1: begin
				kind       = head.r1_kind;
				char_code  = {24'd0, head.r1_code};
				error_code = head.r1_err;
			end
			default: char_code = {24'd0, head.r2_code};
		endcase
	end

	assign last     = (idx_q == head.cnt - 2'd1);
	assign take     = pop && !head_empty;
	assign head_pop = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

### tb/string_literal_unescaper_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the string literal unescaper core.
module string_literal_unescaper_core_tb;
	import slu_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [8*10-1:0] ESC_CHARS = {CH_SQUOTE, CH_DQUOTE, CH_BSL, "abfnrtv"};
	localparam logic [8*22-1:0] HEX_CHARS = "0123456789abcdefABCDEF";
	localparam int ITEM_TARGET = 380;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] code;
		logic [2:0]  err;
		logic        nc;
		logic        last;
	} decoded_t;

	typedef struct packed {
		logic [1:0]  act;
		logic [7:0]  b;
		logic        typed;
		logic [1:0]  kind;
		logic [31:0] code;
		logic [2:0]  err;
	} src_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  action = ACT_NONE;
	logic [7:0]  source_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  kind;
	logic [31:0] char_code;
	logic [2:0]  error_code;
	logic        byte_not_consumed;
	logic        last;

	string_literal_unescaper_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.source_byte(source_byte),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.char_code(char_code),
		.error_code(error_code),
		.byte_not_consumed(byte_not_consumed),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	slu_mode_t   scan = MODE_IDLE;
	logic [7:0]  quote = 8'h00;
	logic        triple = 1'b0;
	logic [1:0]  qrun = 2'd0;
	logic [31:0] acc = 32'd0;
	logic        got_digit = 1'b0;
	logic        ovf = 1'b0;
	decoded_t    step_out[$];
	decoded_t    awaited_results[$];

	src_item_t   cur_item = '0;
	src_item_t   dir_tab [0:26];
	int          mismatches = 0;
	int          items_in = 0;
	int          useful_items = 0;
	int          results_out = 0;
	int          chars_out = 0;
	int          done_out = 0;
	int          errs_out = 0;
	int          full_cycles = 0;
	int          quiet_cycles = 0;
	bit [7:0]    err_seen = '0;
	bit          src_steady = 1'b0;
	bit          sink_steady = 1'b0;
	int          hold_asks = 0;
	int          hold_served = 0;
	int          hold_left = 0;

	function void emit(logic [1:0] k, logic [31:0] c, logic [2:0] e, logic nc);
		decoded_t r;
		r.kind = k;
		r.code = c;
		r.err = e;
		r.nc = nc;
		r.last = 1'b0;
		step_out = {step_out, r};
	endfunction

	function void go_rest();
		scan = MODE_IDLE;
		triple = 1'b0;
		qrun = 2'd0;
		acc = 32'd0;
		got_digit = 1'b0;
		ovf = 1'b0;
	endfunction

	function void abort(logic [2:0] e);
		emit(KIND_ERR, 32'd0, e, 1'b0);
		go_rest();
	endfunction

	function void plain(logic [7:0] b);
		if (b == CH_BSL) begin
			scan = MODE_ESC;
		end else if (b == quote) begin
			emit(KIND_DONE, 32'd0, ERR_NONE, 1'b0);
			go_rest();
		end else begin
			scan = MODE_BODY;
			emit(KIND_CHAR, {24'd0, b}, ERR_NONE, 1'b0);
		end
	endfunction

	function void unescape(logic [7:0] b);
		logic [7:0] c;
		c = 8'd0;
		case (b)
			CH_SQUOTE: c = 8'd39;
			CH_DQUOTE: c = 8'd34;
			CH_BSL:    c = 8'd92;
			"a":       c = 8'd7;
			"b":       c = 8'd8;
			"f":       c = 8'd12;
			"n":       c = 8'd10;
			"r":       c = 8'd13;
			"t":       c = 8'd9;
			"v":       c = 8'd11;
			default:   c = 8'd0;
		endcase
		if (b == "u" || b == "U") begin
			scan = MODE_PLUS;
		end else if (c == 8'd0) begin
			abort(ERR_BADESC);
		end else begin
			scan = MODE_BODY;
			emit(KIND_CHAR, {24'd0, c}, ERR_NONE, 1'b0);
		end
	endfunction

	function int hex_val(logic [7:0] b);
		if (b >= "0" && b <= "9")
			return int'(b) - int'("0");
		if (b >= "a" && b <= "f")
			return int'(b) - int'("a") + 10;
		if (b >= "A" && b <= "F")
			return int'(b) - int'("A") + 10;
		return -1;
	endfunction

	function bit close_code();
		logic [31:0] cp;
		cp = acc;
		close_code = 1'b0;
		if (!got_digit) begin
			abort(ERR_EMPTY);
		end else if (ovf) begin
			abort(ERR_OVFL);
		end else begin
			acc = 32'd0;
			got_digit = 1'b0;
			scan = MODE_BODY;
			emit(KIND_CHAR, cp, ERR_NONE, 1'b0);
			close_code = 1'b1;
		end
	endfunction

	function void raw_byte(logic [7:0] b);
		if (b == quote) begin
			if (qrun >= 2'd2) begin
				emit(KIND_DONE, 32'd0, ERR_NONE, 1'b0);
				go_rest();
			end else begin
				qrun = qrun + 2'd1;
			end
		end else begin
			repeat (qrun) emit(KIND_CHAR, {24'd0, quote}, ERR_NONE, 1'b0);
			qrun = 2'd0;
			emit(KIND_CHAR, {24'd0, b}, ERR_NONE, 1'b0);
		end
	endfunction

	function void decode_item(logic [1:0] act, logic [7:0] b);
		int h;
		step_out.delete();
		case (act)
			ACT_START: begin
				go_rest();
				quote = b;
				scan = MODE_FIRST;
			end
			ACT_BYTE: begin
				case (scan)
					MODE_FIRST: begin
						if (b == quote)
							scan = MODE_SECOND;
						else
							plain(b);
					end
					MODE_SECOND: begin
						if (b == quote) begin
							triple = 1'b1;
							qrun = 2'd0;
							scan = MODE_BODY;
						end else if (quote == CH_BSL) begin
							unescape(b);
						end else begin
							emit(KIND_DONE, 32'd0, ERR_NONE, 1'b1);
							go_rest();
						end
					end
					MODE_BODY: begin
						if (triple)
							raw_byte(b);
						else
							plain(b);
					end
					MODE_ESC: unescape(b);
					MODE_PLUS: begin
						if (b == CH_PLUS)
							scan = MODE_HEX;
						else
							abort(ERR_NOPLUS);
					end
					MODE_HEX: begin
						h = hex_val(b);
						if (h >= 0) begin
							if (acc[31:28] != 4'd0)
								ovf = 1'b1;
							acc = {acc[27:0], 4'(h)};
							got_digit = 1'b1;
						end else if (close_code()) begin
							plain(b);
						end
					end
					default: ;
				endcase
			end
			ACT_END: begin
				case (scan)
					MODE_FIRST, MODE_BODY: abort(ERR_UNTERM);
					MODE_SECOND: begin
						if (quote == CH_BSL) begin
							abort(ERR_BADESC);
						end else begin
							emit(KIND_DONE, 32'd0, ERR_NONE, 1'b0);
							go_rest();
						end
					end
					MODE_ESC: abort(ERR_BADESC);
					MODE_PLUS: abort(ERR_NOPLUS);
					MODE_HEX: begin
						if (close_code())
							abort(ERR_UNTERM);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].last = 1'b1;
	endfunction

	function void flag(string what, decoded_t want, decoded_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: expected kind %0d code %h err %0d nc %0b last %0b,",
				$time, what, want.kind, want.code, want.err, want.nc, want.last);
			$display("    got kind %0d code %h err %0d nc %0b last %0b",
				got.kind, got.code, got.err, got.nc, got.last);
		end
	endfunction

	always @(posedge clk) begin : monitor
		decoded_t got;
		decoded_t want;
		got = '{kind, char_code, error_code, byte_not_consumed, last};
		if (full)
			full_cycles++;
		if (pop && !empty) begin
			results_out++;
			case (kind)
				KIND_CHAR: chars_out++;
				KIND_DONE: done_out++;
				default: begin
					errs_out++;
					err_seen[error_code] = 1'b1;
				end
			endcase
			if (awaited_results.size() == 0) begin
				flag("unexpected result", '0, got);
			end else begin
				want = awaited_results.pop_front();
				if (got.kind !== want.kind || got.code !== want.code
						|| got.err !== want.err
						|| got.nc !== want.nc || got.last !== want.last)
					flag("result mismatch", want, got);
			end
		end
		if (push && !full) begin
			items_in++;
			if (action == ACT_START || (action != ACT_NONE && scan != MODE_IDLE))
				useful_items++;
			decode_item(action, source_byte);
			if (cur_item.typed) begin
				want = '{cur_item.kind, cur_item.code, cur_item.err, 1'b0, 1'b1};
				if (step_out.size() == 0)
					flag("table row without result", want, '0);
				else if (step_out[step_out.size() - 1].kind != want.kind
						|| step_out[step_out.size() - 1].code != want.code
						|| step_out[step_out.size() - 1].err != want.err)
					flag("table row", want, step_out[step_out.size() - 1]);
			end
			awaited_results = {awaited_results, step_out};
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_served != hold_asks) begin
			hold_served = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= sink_steady || ($urandom_range(99) >= 33);
		end
	end

	task automatic offer(src_item_t it);
		int gap;
		gap = 0;
		if (!src_steady)
			while ($urandom_range(99) < 33)
				gap++;
		@(negedge clk);
		repeat (gap) begin
			push <= 1'b0;
			@(negedge clk);
		end
		cur_item = it;
		push <= 1'b1;
		action <= it.act;
		source_byte <= it.b;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic offer_raw(logic [1:0] act, logic [7:0] b);
		offer('{act, b, 1'b0, KIND_CHAR, 32'd0, ERR_NONE});
	endtask

	task automatic send_literal();
		logic [7:0] q;
		logic [7:0] b;
		bit tq;
		int pick;
		int k;
		pick = $urandom_range(9);
		if (pick < 4)
			q = CH_DQUOTE;
		else if (pick < 7)
			q = CH_SQUOTE;
		else if (pick == 7)
			q = CH_BSL;
		else
			q = 8'($urandom_range(255));
		offer_raw(ACT_START, q);
		tq = ($urandom_range(3) == 0);
		if (tq) begin
			offer_raw(ACT_BYTE, q);
			offer_raw(ACT_BYTE, q);
		end
		repeat ($urandom_range(6)) begin
			if (tq) begin
				repeat ($urandom_range(2)) offer_raw(ACT_BYTE, q);
				b = 8'($urandom_range(255));
				if (b == q)
					b = b ^ 8'h01;
				offer_raw(ACT_BYTE, b);
			end else begin
				pick = $urandom_range(9);
				if (pick < 4) begin
					b = 8'($urandom_range(255));
					if (b == q || b == CH_BSL)
						b = (q == "x") ? "y" : "x";
					offer_raw(ACT_BYTE, b);
				end else if (pick < 6) begin
					offer_raw(ACT_BYTE, CH_BSL);
					k = $urandom_range(9);
					offer_raw(ACT_BYTE, ESC_CHARS[8*k +: 8]);
				end else if (pick < 9) begin
					offer_raw(ACT_BYTE, CH_BSL);
					offer_raw(ACT_BYTE, $urandom_range(1) ? "u" : "U");
					offer_raw(ACT_BYTE, CH_PLUS);
					k = $urandom_range(1, 6);
					pick = $urandom_range(9);
					if (pick == 0)
						k = 0;
					else if (pick == 1)
						k = 9;
					repeat (k) offer_raw(ACT_BYTE, HEX_CHARS[8*$urandom_range(21) +: 8]);
				end else begin
					offer_raw(ACT_BYTE, CH_BSL);
					b = 8'($urandom_range(255));
					if ($urandom_range(1)) begin
						offer_raw(ACT_BYTE, "u");
						if (b == CH_PLUS)
							b = "-";
					end
					offer_raw(ACT_BYTE, b);
				end
			end
		end
		pick = $urandom_range(9);
		if (pick < 6) begin
			offer_raw(ACT_BYTE, q);
			if (tq) begin
				offer_raw(ACT_BYTE, q);
				offer_raw(ACT_BYTE, q);
			end
		end else if (pick < 8) begin
			offer_raw(ACT_END, 8'($urandom_range(255)));
		end else if (pick == 9) begin
			repeat ($urandom_range(1, 3))
				offer_raw(2'($urandom_range(3)), 8'($urandom_range(255)));
		end
	endtask

	initial begin
		bit held;
		bit paused;
		held = 1'b0;
		paused = 1'b0;
		dir_tab = '{
			'{ACT_BYTE,  8'hFF,     1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_END,   8'h00,     1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_NONE,  8'h00,     1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_START, CH_DQUOTE, 1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  CH_DQUOTE, 1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  "z",       1'b1, KIND_DONE, 32'd0,   ERR_NONE},
			'{ACT_START, CH_DQUOTE, 1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  8'h00,     1'b1, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  8'hFF,     1'b1, KIND_CHAR, 32'd255, ERR_NONE},
			'{ACT_BYTE,  CH_BSL,    1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  "n",       1'b1, KIND_CHAR, 32'd10,  ERR_NONE},
			'{ACT_BYTE,  CH_BSL,    1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  "u",       1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  CH_PLUS,   1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  "A",       1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  CH_DQUOTE, 1'b1, KIND_DONE, 32'd0,   ERR_NONE},
			'{ACT_START, CH_SQUOTE, 1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  CH_SQUOTE, 1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  CH_SQUOTE, 1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  CH_SQUOTE, 1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  "q",       1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_END,   8'h00,     1'b1, KIND_ERR,  32'd0,   ERR_UNTERM},
			'{ACT_START, CH_BSL,    1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  CH_BSL,    1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_BYTE,  "n",       1'b1, KIND_CHAR, 32'd10,  ERR_NONE},
			'{ACT_BYTE,  CH_BSL,    1'b0, KIND_CHAR, 32'd0,   ERR_NONE},
			'{ACT_END,   8'h00,     1'b1, KIND_ERR,  32'd0,   ERR_BADESC}
		};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (dir_tab[i])
			offer(dir_tab[i]);
		while (items_in < ITEM_TARGET) begin
			if (items_in >= 120 && !held) begin
				hold_asks++;
				held = 1'b1;
			end
			if (items_in >= 200 && !paused) begin
				@(negedge clk);
				push <= 1'b0;
				while (awaited_results.size() != 0)
					@(posedge clk);
				paused = 1'b1;
			end
			src_steady = (items_in >= 240 && items_in < 310);
			sink_steady = src_steady;
			send_literal();
		end
		@(negedge clk);
		push <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		$display("Run: %0d input transactions (%0d effective), %0d results, full %0d cycles",
			items_in, useful_items, results_out, full_cycles);
		$display("Results: %0d characters, %0d closed strings, %0d errors (codes seen %b)",
			chars_out, done_out, errs_out, err_seen[5:1]);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
hw/rtl/slu_pkg.sv
hw/rtl/slu_front.sv
hw/rtl/slu_queue.sv
hw/rtl/slu_back.sv
hw/rtl/string_literal_unescaper_core.sv
tb/string_literal_unescaper_core_tb.sv
